// ----- rtl/les_pkg.sv -----
// Shared types and constants for the LOOK elevator scheduler.
// No dependencies; used by les_pick.sv and look_elevator_scheduler_core.sv.
`default_nettype none

package les_pkg;

  localparam int FLOOR_W    = 10;
  localparam int OP_W       = 2;
  localparam int FLOORS_DEF = 1024;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ACTION = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/les_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module les_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/les_pick.sv -----
// Shared search unit: nearest set bit of one masked 64-bit bitmap word,
// lowest for upward travel, highest for downward. Depends on les_pkg.
`default_nettype none

module les_pick (
  input  wire logic                       down,
  input  wire les_pkg::word_t             word,
  input  wire les_pkg::word_t             mask,
  output logic                            hit,
  output logic [les_pkg::BIT_W-1:0]       idx
);

  les_pkg::word_t              m;
  les_pkg::word_t              w;
  les_pkg::word_t              low;
  logic [les_pkg::BIT_W-1:0]   idx_l;

  always_comb begin
    m = word & mask;
    // reverse for downward travel so the highest bit becomes the lowest
    for (int i = 0; i < les_pkg::WORD_BITS; i++) begin
      w[i] = down ? m[les_pkg::WORD_BITS-1-i] : m[i];
    end
    low = w & (~w + 1'b1);
    for (int b = 0; b < les_pkg::BIT_W; b++) begin
      idx_l[b] = 1'b0;
      for (int i = 0; i < les_pkg::WORD_BITS; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx_l[b] = idx_l[b] | low[i];
        end
      end
    end
    hit = |w;
    idx = down ? ~idx_l : idx_l;
  end

endmodule

`default_nettype wire

// ----- rtl/look_elevator_scheduler_core.sv -----
// LOOK elevator scheduler: pending-floor bitmap in RAM, 64 floors per word.
// After reset a clearing pass writes every word with input stalled.
// Add/cancel: read-modify-write of one word (S_RMW_RD, then S_RMW_WR).
// Locate: S_LOC loads the result register once no stalled result is pending.
// Action: one RAM word per cycle; with no hit the direction flips and the scan repeats.
// Reset is synchronous; it clears floor, direction, fill count and control.
`default_nettype none

module look_elevator_scheduler_core #(
  parameter int FLOORS = les_pkg::FLOORS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [les_pkg::OP_W-1:0]     op,
  input  wire logic [les_pkg::FLOOR_W-1:0]  floor,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [les_pkg::FLOOR_W-1:0]       reported_floor
);

  localparam int FW    = les_pkg::FLOOR_W;
  localparam int BW    = les_pkg::BIT_W;
  localparam int WORDS = (FLOORS + les_pkg::WORD_BITS - 1) / les_pkg::WORD_BITS;
  localparam int WAW   = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(FLOORS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_SCAN,
    S_LOC
  } state_t;

  state_t               state;
  les_pkg::op_t         op_q;
  logic [FW-1:0]        floor_q;
  logic [FW-1:0]        cur;
  logic                 down;
  logic [CW-1:0]        count;
  logic [WAW-1:0]       ptr;
  logic [WAW-1:0]       dptr;
  logic                 dvalid;
  logic                 issue_done;
  logic                 second;

  logic [WAW-1:0]       cur_word;
  logic [WAW-1:0]       f_word;
  logic [BW-1:0]        f_bit;
  logic                 f_in_range;
  logic [WAW-1:0]       end_word;
  les_pkg::word_t       scan_mask;
  les_pkg::word_t       f_mask;
  logic                 hit;
  logic [BW-1:0]        idx;
  logic                 hit_take;
  logic                 miss_end;
  logic [FW-1:0]        target;

  logic                 wr_en;
  logic [WAW-1:0]       wr_addr;
  les_pkg::word_t       wr_data;
  logic [WAW-1:0]       rd_addr;
  les_pkg::word_t       rd_data;

  les_ram #(
    .WIDTH (les_pkg::WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  les_pick u_pick (
    .down (down),
    .word (rd_data),
    .mask (scan_mask),
    .hit  (hit),
    .idx  (idx)
  );

  always_comb begin
    cur_word   = WAW'(cur >> BW);
    f_word     = WAW'(floor_q >> BW);
    f_bit      = floor_q[BW-1:0];
    f_in_range = int'(floor_q) < FLOORS;
    f_mask     = les_pkg::word_t'(1) << f_bit;
    end_word   = down ? '0 : WAW'(WORDS - 1);
    // in the car's own word only floors strictly beyond it count
    if (dptr == cur_word) begin
      scan_mask = down ? ~({les_pkg::WORD_BITS{1'b1}} << cur[BW-1:0])
                       : ({les_pkg::WORD_BITS{1'b1}} << cur[BW-1:0]) << 1;
    end else begin
      scan_mask = {les_pkg::WORD_BITS{1'b1}};
    end
    hit_take = (state == S_SCAN) && dvalid && hit;
    miss_end = (state == S_SCAN) && dvalid && !hit && (dptr == end_word);
    target   = FW'({dptr, idx});

    rd_addr = (state == S_SCAN) ? ptr : f_word;
    wr_en   = 1'b0;
    wr_addr = f_word;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = '0;
      end
      S_RMW_WR: begin
        wr_en   = f_in_range;
        wr_data = (op_q == les_pkg::OP_ADD) ? (rd_data | f_mask) : (rd_data & ~f_mask);
      end
      S_SCAN: begin
        wr_en   = hit_take;
        wr_addr = dptr;
        wr_data = rd_data & ~(les_pkg::word_t'(1) << idx);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase

    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      cur        <= '0;
      down       <= 1'b0;
      count      <= '0;
      dvalid     <= 1'b0;
      issue_done <= 1'b0;
      second     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == WAW'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= les_pkg::op_t'(op);
            floor_q <= floor;
            case (les_pkg::op_t'(op))
              les_pkg::OP_ADD, les_pkg::OP_CANCEL: begin
                state <= S_RMW_RD;
              end
              les_pkg::OP_ACTION: begin
                if (count != '0) begin
                  ptr        <= cur_word;
                  dvalid     <= 1'b0;
                  issue_done <= 1'b0;
                  second     <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              les_pkg::OP_LOCATE: begin
                state <= S_LOC;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          // keep the fill count exact: repeated adds and stray cancels do nothing
          if (f_in_range) begin
            if (op_q == les_pkg::OP_ADD && !rd_data[f_bit]) begin
              count <= count + 1'b1;
            end else if (op_q == les_pkg::OP_CANCEL && rd_data[f_bit]) begin
              count <= count - 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          dvalid <= !issue_done;
          dptr   <= ptr;
          if (!issue_done) begin
            if (ptr == end_word) begin
              issue_done <= 1'b1;
            end else begin
              ptr <= down ? ptr - 1'b1 : ptr + 1'b1;
            end
          end
          if (hit_take) begin
            cur    <= target;
            count  <= count - 1'b1;
            dvalid <= 1'b0;
            state  <= S_IDLE;
          end else if (miss_end) begin
            dvalid <= 1'b0;
            if (!second) begin
              // flip and restart from the car's word the other way
              down       <= !down;
              second     <= 1'b1;
              ptr        <= cur_word;
              issue_done <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_LOC: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            reported_floor <= cur;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_move_strict: assert property (@(posedge clk) disable iff (rst)
    hit_take |=> cur != $past(cur))
    else $error("action served the current floor");

  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && op == les_pkg::OP_ACTION && count == '0)
      |=> state == S_IDLE && $stable(cur) && $stable(down))
    else $error("action on an empty set changed state");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_LOC)
    else $error("result produced outside a locate");

endmodule

`default_nettype wire
